### rtl/core/ghit_pkg.sv
// shared types, widths and codes of the pick hit test
// no dependencies
package ghit_pkg;

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int COORD_FRAC_BITS = 8;

    localparam int CRD_W  = 24;
    localparam int PIX_W  = 12;
    localparam int HD_W   = 16;
    localparam int MRG_W  = 8;
    localparam int SLOT_W = 5;
    localparam int KIND_W = 3;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam int PW    = PIX_W + 1 + COORD_FRAC_BITS;
    localparam int DW    = imax(PW, CRD_W) + 1;
    localparam int PRW   = 2 * DW;
    localparam int SW    = PRW + 1;
    localparam int HW    = (SW + 1) / 2;
    localparam int CSQ_W = 2 * SW;
    localparam int TL_W  = HD_W + SW + 2 * COORD_FRAC_BITS;
    localparam int BW    = imax(CSQ_W, TL_W) + 1;
    localparam int RW    = imax(CRD_W, MRG_W + COORD_FRAC_BITS + 1) + 1;
    localparam int RSQ_W = 2 * RW;
    localparam int ENTRY_W = KIND_W + 1 + 4 * CRD_W;
    localparam int IN_W  = 136;
    localparam int OUT_W = 16;

    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POINT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RAY     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEGMENT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CIRCLE  = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HIT_DIST   = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_CIRC_MARGIN = 2'd3;

    localparam logic [HD_W-1:0]  HIT_DIST_RST = 16'd25;
    localparam logic [MRG_W-1:0] MARGIN_RST   = 8'd5;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_POINT,
        CLS_LINE,
        CLS_CIRCLE
    } cls_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              shown;
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
    } tag_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              hit;
        cls_t              cls;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
    } res_t;

endpackage

### rtl/core/ghit_ram.sv
// generic single write port ram with registered read
// no dependencies
module ghit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/ghit_eval.sv
// pipelined distance test of one table entry against the query point
// depends on ghit_pkg
module ghit_eval (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ghit_pkg::tag_t                    tag_in,
    input  logic signed [ghit_pkg::CRD_W-1:0] ax,
    input  logic signed [ghit_pkg::CRD_W-1:0] ay,
    input  logic signed [ghit_pkg::CRD_W-1:0] bx,
    input  logic signed [ghit_pkg::CRD_W-1:0] by,
    input  logic signed [ghit_pkg::PW-1:0]    px,
    input  logic signed [ghit_pkg::PW-1:0]    py,
    input  logic [ghit_pkg::HD_W-1:0]         hit_dist_sq,
    input  logic [ghit_pkg::MRG_W-1:0]        circle_margin,
    output ghit_pkg::res_t                    res
);
    import ghit_pkg::*;

    localparam int F = COORD_FRAC_BITS;

    // stage 2: differences
    logic signed [DW-1:0] v1x_next, v1y_next, v2x_next, v2y_next, dx_next, dy_next;
    logic signed [DW-1:0] v1x_reg, v1y_reg, v2x_reg, v2y_reg, dx_reg, dy_reg;
    logic signed [RW-1:0] mw, rr, chi_next, clo_next, chi_reg, clo_reg;
    tag_t t2_reg;

    // stage 3: products
    logic signed [PRW-1:0] s11_next, s12_next, s21_next, s22_next, l1_next, l2_next;
    logic signed [PRW-1:0] o11_next, o12_next, o21_next, o22_next, c1_next, c2_next;
    logic signed [PRW-1:0] s11_reg, s12_reg, s21_reg, s22_reg, l1_reg, l2_reg;
    logic signed [PRW-1:0] o11_reg, o12_reg, o21_reg, o22_reg, c1_reg, c2_reg;
    logic signed [RSQ_W-1:0] hsq_next, lsq_next, hsq_reg, lsq_reg;
    logic chp_next, cln_next, chp_reg, cln_reg;
    tag_t t3_reg;

    // stage 4: sums and short compares
    logic signed [SW-1:0] d1s, d2s, dot1, dot2, crs, lns;
    logic [SW-1:0] d1u, d2u;
    logic [HD_W+2*F-1:0] thr;
    logic [SW-1:0] cmag_next, len_next, cmag_reg, len_reg;
    logic pa_next, pb_next, lz_next, d1lt_next, d2lt_next, circ_next;
    logic pa_reg, pb_reg, lz_reg, d1lt_reg, d2lt_reg, circ_reg;
    tag_t t4_reg;

    // stage 5: partial products
    logic [2*(SW-HW)-1:0]  hh_next, hh_reg;
    logic [SW-1:0]         hl_next, hl_reg;
    logic [2*HW-1:0]       ll_next, ll_reg;
    logic [HD_W+SW-HW-1:0] th_next, th_reg;
    logic [HD_W+HW-1:0]    tlo_next, tlo_reg;
    logic pa5_reg, pb5_reg, lz5_reg, d1lt5_reg, d2lt5_reg, circ5_reg;
    tag_t t5_reg;

    // stage 6: wide sums
    logic [BW-1:0] csq_next, tl_next, csq_reg, tl_reg;
    logic pa6_reg, pb6_reg, lz6_reg, d1lt6_reg, d2lt6_reg, circ6_reg;
    tag_t t6_reg;

    res_t res_next, res_reg;
    logic cross_lt;

    always_comb begin
        v1x_next = DW'(px) - DW'(ax);
        v1y_next = DW'(py) - DW'(ay);
        v2x_next = DW'(px) - DW'(bx);
        v2y_next = DW'(py) - DW'(by);
        dx_next  = DW'(bx) - DW'(ax);
        dy_next  = DW'(by) - DW'(ay);
        mw       = RW'($signed({1'b0, circle_margin})) <<< F;
        rr       = RW'(bx);
        chi_next = rr + mw;
        clo_next = rr - mw;
    end

    always_comb begin
        s11_next = v1x_reg * v1x_reg;
        s12_next = v1y_reg * v1y_reg;
        s21_next = v2x_reg * v2x_reg;
        s22_next = v2y_reg * v2y_reg;
        l1_next  = dx_reg * dx_reg;
        l2_next  = dy_reg * dy_reg;
        o11_next = v1x_reg * dx_reg;
        o12_next = v1y_reg * dy_reg;
        o21_next = v2x_reg * dx_reg;
        o22_next = v2y_reg * dy_reg;
        c1_next  = v1x_reg * dy_reg;
        c2_next  = v1y_reg * dx_reg;
        hsq_next = chi_reg * chi_reg;
        lsq_next = clo_reg * clo_reg;
        chp_next = chi_reg > 0;
        cln_next = clo_reg < 0;
    end

    always_comb begin
        d1s  = SW'(s11_reg) + SW'(s12_reg);
        d2s  = SW'(s21_reg) + SW'(s22_reg);
        lns  = SW'(l1_reg) + SW'(l2_reg);
        dot1 = SW'(o11_reg) + SW'(o12_reg);
        dot2 = SW'(o21_reg) + SW'(o22_reg);
        crs  = SW'(c1_reg) - SW'(c2_reg);
        d1u  = $unsigned(d1s);
        d2u  = $unsigned(d2s);
        thr  = {hit_dist_sq, {(2 * F){1'b0}}};
        cmag_next = (crs < 0) ? $unsigned(-crs) : $unsigned(crs);
        len_next  = $unsigned(lns);
        pa_next   = dot1 > 0;
        pb_next   = dot2 > 0;
        lz_next   = lns == '0;
        d1lt_next = d1u < thr;
        d2lt_next = d2u < thr;
        circ_next = chp_reg && (d1u < $unsigned(hsq_reg))
                    && (cln_reg || (d1u > $unsigned(lsq_reg)));
    end

    always_comb begin
        hh_next  = cmag_reg[SW-1:HW] * cmag_reg[SW-1:HW];
        hl_next  = cmag_reg[SW-1:HW] * cmag_reg[HW-1:0];
        ll_next  = cmag_reg[HW-1:0] * cmag_reg[HW-1:0];
        th_next  = hit_dist_sq * len_reg[SW-1:HW];
        tlo_next = hit_dist_sq * len_reg[HW-1:0];
    end

    always_comb begin
        csq_next = (BW'(hh_reg) << (2 * HW)) + (BW'(hl_reg) << (HW + 1)) + BW'(ll_reg);
        tl_next  = ((BW'(th_reg) << HW) + BW'(tlo_reg)) << (2 * F);
    end

    always_comb begin
        cross_lt = csq_reg < tl_reg;
        res_next.valid = t6_reg.valid;
        res_next.last  = t6_reg.last;
        res_next.slot  = t6_reg.slot;
        res_next.kind  = t6_reg.kind;
        res_next.hit   = 1'b0;
        res_next.cls   = CLS_NONE;
        case (t6_reg.kind)
            KIND_POINT: begin
                res_next.cls = CLS_POINT;
                res_next.hit = d1lt6_reg;
            end
            KIND_LINE, KIND_RAY, KIND_SEGMENT: begin
                res_next.cls = CLS_LINE;
                if (lz6_reg) begin
                    res_next.hit = 1'b0;
                end else if (t6_reg.kind != KIND_LINE && !pa6_reg) begin
                    res_next.hit = d1lt6_reg;
                end else if (t6_reg.kind == KIND_SEGMENT && pb6_reg) begin
                    res_next.hit = d2lt6_reg;
                end else begin
                    res_next.hit = cross_lt;
                end
            end
            KIND_CIRCLE: begin
                res_next.cls = CLS_CIRCLE;
                res_next.hit = circ6_reg;
            end
            default: begin
                res_next.cls = CLS_NONE;
                res_next.hit = 1'b0;
            end
        endcase
        if (!t6_reg.shown || !t6_reg.valid) begin
            res_next.hit = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        v1x_reg <= v1x_next; v1y_reg <= v1y_next;
        v2x_reg <= v2x_next; v2y_reg <= v2y_next;
        dx_reg  <= dx_next;  dy_reg  <= dy_next;
        chi_reg <= chi_next; clo_reg <= clo_next;

        s11_reg <= s11_next; s12_reg <= s12_next;
        s21_reg <= s21_next; s22_reg <= s22_next;
        l1_reg  <= l1_next;  l2_reg  <= l2_next;
        o11_reg <= o11_next; o12_reg <= o12_next;
        o21_reg <= o21_next; o22_reg <= o22_next;
        c1_reg  <= c1_next;  c2_reg  <= c2_next;
        hsq_reg <= hsq_next; lsq_reg <= lsq_next;
        chp_reg <= chp_next; cln_reg <= cln_next;

        cmag_reg <= cmag_next; len_reg <= len_next;
        pa_reg <= pa_next; pb_reg <= pb_next; lz_reg <= lz_next;
        d1lt_reg <= d1lt_next; d2lt_reg <= d2lt_next; circ_reg <= circ_next;

        hh_reg <= hh_next; hl_reg <= hl_next; ll_reg <= ll_next;
        th_reg <= th_next; tlo_reg <= tlo_next;
        pa5_reg <= pa_reg; pb5_reg <= pb_reg; lz5_reg <= lz_reg;
        d1lt5_reg <= d1lt_reg; d2lt5_reg <= d2lt_reg; circ5_reg <= circ_reg;

        csq_reg <= csq_next; tl_reg <= tl_next;
        pa6_reg <= pa5_reg; pb6_reg <= pb5_reg; lz6_reg <= lz5_reg;
        d1lt6_reg <= d1lt5_reg; d2lt6_reg <= d2lt5_reg; circ6_reg <= circ5_reg;

        if (!aresetn) begin
            t2_reg  <= '0;
            t3_reg  <= '0;
            t4_reg  <= '0;
            t5_reg  <= '0;
            t6_reg  <= '0;
            res_reg <= '0;
        end else begin
            t2_reg  <= tag_in;
            t3_reg  <= t2_reg;
            t4_reg  <= t3_reg;
            t5_reg  <= t4_reg;
            t6_reg  <= t5_reg;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule

### rtl/core/geometry_pick_hit_test.sv
// top level of the pick hit test: request channels, config registers, scan control
// depends on ghit_pkg, ghit_ram, ghit_eval
//
// usage
//   s_ channel carries requests: tuser 0 loads a table slot, tuser 1 is a
//   hit query on a mouse pixel. a load gives no result and leaves s_tready high.
//   a query gives exactly one result on the m_ channel: hit flag, slot and
//   kind of the picked shape (priority points, lines/rays/segments, circles,
//   higher slot first within a class).
//   a query walks the table one entry per cycle through the shape ram and
//   the distance pipeline; s_tready stays low from accept until the result
//   is loaded into the output register, so no new request is taken while
//   a query runs.
//   config writes land at once on cfg_wr_en; write them only while idle.
//   after reset the shape ram is cleared, one entry per cycle; s_tready
//   stays low during that pass.
//   the result sits in an output register until m_tready takes it; a new
//   request is accepted meanwhile, and a finished query waits for the
//   output register to free up.
module geometry_pick_hit_test #(
    parameter int TABLE_DEPTH = ghit_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // slot[4:0] kind[7:5] shown[8] first_x[32:9] first_y[56:33]
    // second_x[80:57] second_y[104:81] mouse_x[116:105] mouse_y[128:117]
    input  logic [ghit_pkg::IN_W-1:0]   s_tdata,
    // op[0]
    input  logic                        s_tuser,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // hit[0] hit_slot[5:1] hit_kind[8:6]
    output logic [ghit_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_wr_en,
    input  logic [ghit_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [ghit_pkg::CFG_DW-1:0] cfg_wdata
);
    import ghit_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int F  = COORD_FRAC_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [AW-1:0] addr_reg;
    logic [PIX_W-1:0] origin_x_reg, origin_y_reg;
    logic [HD_W-1:0] hit_dist_reg;
    logic [MRG_W-1:0] margin_reg;
    logic signed [PW-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [PIX_W:0] ddx, ddy;
    logic pt_hit_reg, ln_hit_reg, ci_hit_reg;
    logic [SLOT_W-1:0] pt_slot_reg, ln_slot_reg, ci_slot_reg;
    logic [KIND_W-1:0] ln_kind_reg;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic tvalid_q_reg, tlast_q_reg;
    logic [SLOT_W-1:0] tslot_q_reg;

    logic [SLOT_W-1:0] in_slot;
    logic [KIND_W-1:0] in_kind;
    logic in_shown;
    logic [4*CRD_W-1:0] in_coords;
    logic [PIX_W-1:0] in_mx, in_my;
    logic [AW+SLOT_W-1:0] wslot_ext, idx_ext;
    logic in_range, req;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    tag_t tag;
    res_t res;

    assign in_slot   = s_tdata[4:0];
    assign in_kind   = s_tdata[7:5];
    assign in_shown  = s_tdata[8];
    assign in_coords = s_tdata[104:9];
    assign in_mx     = s_tdata[116:105];
    assign in_my     = s_tdata[128:117];

    assign s_tready  = state_reg == ST_IDLE;
    assign req       = s_tvalid && s_tready;
    assign wslot_ext = {{AW{1'b0}}, in_slot};
    assign in_range  = wslot_ext < (AW + SLOT_W)'(TABLE_DEPTH);
    assign idx_ext   = {{SLOT_W{1'b0}}, addr_reg};

    // entry layout: by, bx, ay, ax, shown, kind from the top
    assign ram_we    = (state_reg == ST_CLEAR) || (req && s_tuser == OP_WRITE && in_range);
    assign ram_waddr = (state_reg == ST_CLEAR) ? addr_reg : wslot_ext[AW-1:0];
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : {in_coords, in_shown, in_kind};

    ghit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        tag.valid = tvalid_q_reg;
        tag.last  = tlast_q_reg;
        tag.slot  = tslot_q_reg;
        tag.kind  = ram_rdata[KIND_W-1:0];
        tag.shown = ram_rdata[KIND_W];
    end

    ghit_eval u_eval (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tag_in        (tag),
        .ax            (ram_rdata[KIND_W+1 +: CRD_W]),
        .ay            (ram_rdata[KIND_W+1+CRD_W +: CRD_W]),
        .bx            (ram_rdata[KIND_W+1+2*CRD_W +: CRD_W]),
        .by            (ram_rdata[KIND_W+1+3*CRD_W +: CRD_W]),
        .px            (px_reg),
        .py            (py_reg),
        .hit_dist_sq   (hit_dist_reg),
        .circle_margin (margin_reg),
        .res           (res)
    );

    always_comb begin
        ddx     = $signed({1'b0, in_mx}) - $signed({1'b0, origin_x_reg});
        ddy     = $signed({1'b0, origin_y_reg}) - $signed({1'b0, in_my});
        px_next = PW'(ddx) <<< F;
        py_next = PW'(ddy) <<< F;
    end

    always_comb begin
        m_data_next = '0;
        if (pt_hit_reg) begin
            m_data_next[8:0] = {KIND_POINT, pt_slot_reg, 1'b1};
        end else if (ln_hit_reg) begin
            m_data_next[8:0] = {ln_kind_reg, ln_slot_reg, 1'b1};
        end else if (ci_hit_reg) begin
            m_data_next[8:0] = {KIND_CIRCLE, ci_slot_reg, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            hit_dist_reg <= HIT_DIST_RST;
            margin_reg   <= MARGIN_RST;
            m_tvalid_reg <= 1'b0;
            tvalid_q_reg <= 1'b0;
            tlast_q_reg  <= 1'b0;
            pt_hit_reg   <= 1'b0;
            ln_hit_reg   <= 1'b0;
            ci_hit_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ORIGIN_X:    origin_x_reg <= cfg_wdata[PIX_W-1:0];
                    CFG_ORIGIN_Y:    origin_y_reg <= cfg_wdata[PIX_W-1:0];
                    CFG_HIT_DIST:    hit_dist_reg <= cfg_wdata;
                    CFG_CIRC_MARGIN: margin_reg   <= cfg_wdata[MRG_W-1:0];
                    default: ;
                endcase
            end

            tvalid_q_reg <= state_reg == ST_SCAN;
            tlast_q_reg  <= addr_reg == '0;
            tslot_q_reg  <= idx_ext[SLOT_W-1:0];

            // first hit per class wins, entries arrive highest slot first
            if (res.valid && res.hit) begin
                case (res.cls)
                    CLS_POINT: begin
                        if (!pt_hit_reg) begin
                            pt_hit_reg  <= 1'b1;
                            pt_slot_reg <= res.slot;
                        end
                    end
                    CLS_LINE: begin
                        if (!ln_hit_reg) begin
                            ln_hit_reg  <= 1'b1;
                            ln_slot_reg <= res.slot;
                            ln_kind_reg <= res.kind;
                        end
                    end
                    CLS_CIRCLE: begin
                        if (!ci_hit_reg) begin
                            ci_hit_reg  <= 1'b1;
                            ci_slot_reg <= res.slot;
                        end
                    end
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (addr_reg == AW'(TABLE_DEPTH - 1)) begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid && s_tuser == OP_QUERY) begin
                        px_reg     <= px_next;
                        py_reg     <= py_next;
                        pt_hit_reg <= 1'b0;
                        ln_hit_reg <= 1'b0;
                        ci_hit_reg <= 1'b0;
                        addr_reg   <= AW'(TABLE_DEPTH - 1);
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    addr_reg <= addr_reg - 1'b1;
                    if (addr_reg == '0) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (res.valid && res.last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_data_reg   <= m_data_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_res_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("pipeline result outside a query scan");

    a_ram_wr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("shape ram written during a scan");

    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_data_reg[0]) |-> (m_data_reg[8:1] == '0))
        else $error("miss result carries slot or kind");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised without a finished query");
endmodule
